/* sv/mbrp_pkg.sv */
// Shared types, constants and the CRC16 byte update for the Modbus RTU read probe.
`timescale 1ns / 1ps

package mbrp_pkg;

  // Input command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_REG = 2'd0;
  localparam logic [1:0] CFG_REG_COUNT = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  // Configuration reset values
  localparam logic [15:0] FIRST_REG_RST = 16'h07D0;
  localparam logic [6:0]  REG_COUNT_RST = 7'd4;
  localparam logic [15:0] TIMEOUT_RST   = 16'd200;

  // Protocol constants
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FUNC_READ = 8'h03;
  localparam logic [8:0]  RX_MAX    = 9'd511;
  localparam logic [8:0]  RX_MIN    = 9'd4;
  localparam logic [8:0]  RX_EXTRA  = 9'd5;

  // Output kinds
  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Accepted beat as seen by the receive tracker
  typedef struct packed {
    logic       start;
    logic       rx;
    logic       tick;
    logic [7:0] probe_id;
    logic [7:0] rx_byte;
  } rx_cmd_t;

  // Verdict produced by the receive tracker
  typedef struct packed {
    logic valid;
    logic found;
  } verdict_t;

  // CRC16 (reflected) update by one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* sv/mbrp_rx.sv */
// Receive tracker: probe state, lagging CRC, byte counter, timeout and verdict.
`timescale 1ns / 1ps

module mbrp_rx (
  input  logic              clk,
  input  logic              rst_n,
  input  mbrp_pkg::rx_cmd_t cmd,
  input  logic [15:0]       timeout_ticks,
  output mbrp_pkg::verdict_t verdict
);
  import mbrp_pkg::*;

  logic        active_r,  active_nxt;
  logic [7:0]  exp_id_r,  exp_id_nxt;
  logic [8:0]  cnt_r,     cnt_nxt;
  logic [15:0] crc_r,     crc_nxt;
  logic [7:0]  held0_r,   held0_nxt;
  logic [7:0]  held1_r,   held1_nxt;
  logic [7:0]  first_r,   first_nxt;
  logic [7:0]  func_r,    func_nxt;
  logic [7:0]  count_r,   count_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic        done;
  logic        ok;

  // Next state and verdict for the accepted beat
  always_comb begin
    active_nxt  = active_r;
    exp_id_nxt  = exp_id_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    held0_nxt   = held0_r;
    held1_nxt   = held1_r;
    first_nxt   = first_r;
    func_nxt    = func_r;
    count_nxt   = count_r;
    elapsed_nxt = elapsed_r;
    done        = 1'b0;
    ok          = 1'b0;
    priority if (cmd.start) begin
      // restart with cleared reception
      active_nxt  = 1'b1;
      exp_id_nxt  = cmd.probe_id;
      cnt_nxt     = '0;
      crc_nxt     = CRC_INIT;
      held0_nxt   = '0;
      held1_nxt   = '0;
      first_nxt   = '0;
      func_nxt    = '0;
      count_nxt   = '0;
      elapsed_nxt = '0;
    end else if (cmd.rx && active_r) begin
      // fold the byte leaving the holding line into the CRC
      if (cnt_r >= 9'd2) begin
        crc_nxt = crc_byte(crc_r, held0_r);
      end
      held0_nxt = held1_r;
      held1_nxt = cmd.rx_byte;
      if (cnt_r == 9'd0) begin
        first_nxt = cmd.rx_byte;
      end else if (cnt_r == 9'd1) begin
        func_nxt = cmd.rx_byte;
      end else if (cnt_r == 9'd2) begin
        count_nxt = cmd.rx_byte;
      end
      if (cnt_r < RX_MAX) begin
        cnt_nxt = cnt_r + 9'd1;
      end
      done = (cnt_nxt >= RX_MIN) && (func_nxt == FUNC_READ) &&
             (cnt_nxt >= ({1'b0, count_nxt} + RX_EXTRA));
    end else if (cmd.tick && active_r) begin
      // saturating tick count against the timeout
      if (elapsed_r != 16'hFFFF) begin
        elapsed_nxt = elapsed_r + 16'd1;
      end
      done = (elapsed_nxt >= timeout_ticks);
    end else begin
      // hold state on an idle cycle or an ignored beat
    end
    ok = (cnt_nxt >= RX_MIN) && (first_nxt == exp_id_nxt) && (func_nxt == FUNC_READ) &&
         ({held1_nxt, held0_nxt} == crc_nxt);
    if (done) begin
      active_nxt = 1'b0;
    end
  end

  assign verdict.valid = done;
  assign verdict.found = ok;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      exp_id_r  <= '0;
      cnt_r     <= '0;
      crc_r     <= CRC_INIT;
      held0_r   <= '0;
      held1_r   <= '0;
      first_r   <= '0;
      func_r    <= '0;
      count_r   <= '0;
      elapsed_r <= '0;
    end else begin
      active_r  <= active_nxt;
      exp_id_r  <= exp_id_nxt;
      cnt_r     <= cnt_nxt;
      crc_r     <= crc_nxt;
      held0_r   <= held0_nxt;
      held1_r   <= held1_nxt;
      first_r   <= first_nxt;
      func_r    <= func_nxt;
      count_r   <= count_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

/* sv/modbus_rtu_read_probe_core.sv */
// Top level of the Modbus RTU read-holding-registers probe.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready) takes commands: start (with in_probe_id),
//   received bus byte (in_rx_byte) or time tick. Output channel (out_valid/
//   out_ready) delivers request bytes (out_kind 0, out_tx_byte, out_last on the
//   eighth) and probe verdicts (out_kind 1, out_found).
//   Config channel (cfg_valid/cfg_ready, always ready) writes first register,
//   register count and timeout; write it only while no results are pending.
// Timing:
//   Results appear in the cycle after the input beat. While out_ready is high, byte
//   and tick beats are taken every cycle; a start yields eight request beats, one per
//   cycle, and the input is held off until the eighth is taken. The request CRC is
//   built one byte per output beat by a single byte-wide CRC unit.
// Reset: synchronous, active low; clears probe state and restores config defaults.
// Stall: a waiting result holds in the output register; the input is taken in the
//   same cycle the last pending beat leaves, otherwise it waits.
module modbus_rtu_read_probe_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_probe_id,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_tx_byte,
  output logic        out_last,
  output logic        out_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import mbrp_pkg::*;

  // Request byte positions
  localparam logic [2:0] POS_ADDR   = 3'd0;
  localparam logic [2:0] POS_FUNC   = 3'd1;
  localparam logic [2:0] POS_REG_HI = 3'd2;
  localparam logic [2:0] POS_REG_LO = 3'd3;
  localparam logic [2:0] POS_CNT_HI = 3'd4;
  localparam logic [2:0] POS_CNT_LO = 3'd5;
  localparam logic [2:0] POS_CRC_LO = 3'd6;
  localparam logic [2:0] POS_CRC_HI = 3'd7;

  logic [15:0] first_reg_r;
  logic [6:0]  reg_count_r;
  logic [15:0] timeout_r;

  logic        out_valid_r;
  logic        kind_r;
  logic        found_r;
  logic [2:0]  idx_r;
  logic [7:0]  tx_id_r;
  logic [15:0] tx_crc_r;

  logic        in_fire;
  logic        out_fire;
  logic        final_beat;
  logic        take_start;
  logic [7:0]  req_byte;
  rx_cmd_t     rx_cmd;
  verdict_t    verdict;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_reg_r <= FIRST_REG_RST;
      reg_count_r <= REG_COUNT_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_FIRST_REG) begin
        first_reg_r <= cfg_data;
      end else if (cfg_index == CFG_REG_COUNT) begin
        reg_count_r <= cfg_data[6:0];
      end else if (cfg_index == CFG_TIMEOUT) begin
        timeout_r <= cfg_data;
      end
    end
  end

  // Handshake: accept when no result is pending or the last one leaves now
  assign out_fire   = out_valid_r && out_ready;
  assign final_beat = (kind_r == KIND_VERDICT) || (idx_r == POS_CRC_HI);
  assign in_ready   = !out_valid_r || (out_ready && final_beat);
  assign in_fire    = in_valid && in_ready;
  assign take_start = in_fire && (in_command == CMD_START);

  assign rx_cmd.start    = take_start;
  assign rx_cmd.rx       = in_fire && (in_command == CMD_BYTE);
  assign rx_cmd.tick     = in_fire && (in_command == CMD_TICK);
  assign rx_cmd.probe_id = in_probe_id;
  assign rx_cmd.rx_byte  = in_rx_byte;

  mbrp_rx u_rx (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (rx_cmd),
    .timeout_ticks (timeout_r),
    .verdict       (verdict)
  );

  // Select the request byte at the current position
  always_comb begin
    unique case (idx_r)
      POS_ADDR:   req_byte = tx_id_r;
      POS_FUNC:   req_byte = FUNC_READ;
      POS_REG_HI: req_byte = first_reg_r[15:8];
      POS_REG_LO: req_byte = first_reg_r[7:0];
      POS_CNT_HI: req_byte = 8'h00;
      POS_CNT_LO: req_byte = {1'b0, reg_count_r};
      POS_CRC_LO: req_byte = tx_crc_r[7:0];
      POS_CRC_HI: req_byte = tx_crc_r[15:8];
      default:    req_byte = 8'h00;
    endcase
  end

  // Output register and request sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      kind_r      <= KIND_TX;
      found_r     <= 1'b0;
      idx_r       <= '0;
      tx_id_r     <= '0;
      tx_crc_r    <= CRC_INIT;
    end else begin
      priority if (take_start) begin
        out_valid_r <= 1'b1;
        kind_r      <= KIND_TX;
        found_r     <= 1'b0;
        idx_r       <= POS_ADDR;
        tx_id_r     <= in_probe_id;
        tx_crc_r    <= CRC_INIT;
      end else if (verdict.valid) begin
        out_valid_r <= 1'b1;
        kind_r      <= KIND_VERDICT;
        found_r     <= verdict.found;
      end else if (out_fire) begin
        if (final_beat) begin
          out_valid_r <= 1'b0;
        end else begin
          // advance and fold the sent byte into the request CRC unless it is a CRC byte
          idx_r <= idx_r + 3'd1;
          if (idx_r < POS_CRC_LO) begin
            tx_crc_r <= crc_byte(tx_crc_r, req_byte);
          end
        end
      end else begin
        // hold the waiting beat
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = kind_r;
  assign out_tx_byte = (kind_r == KIND_TX) ? req_byte : 8'h00;
  assign out_last    = (kind_r == KIND_TX) && (idx_r == POS_CRC_HI);
  assign out_found   = (kind_r == KIND_VERDICT) && found_r;

`ifndef SYNTHESIS
  // A start begins its request at the address byte
  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    take_start |=> (out_valid && out_kind == KIND_TX && idx_r == POS_ADDR))
    else $error("start did not begin request at address byte");

  // No input is taken while request bytes other than the last remain
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && kind_r == KIND_TX && idx_r != POS_CRC_HI) |-> !in_ready)
    else $error("input taken during request emission");

  // A verdict carries no request byte and no last flag
  a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_VERDICT) |-> (!out_last && out_tx_byte == 8'h00))
    else $error("verdict beat carries request fields");
`endif

endmodule

/* verif/modbus_rtu_read_probe_core_tb.sv */
// Self-checking testbench for the Modbus RTU read probe core: random-gapped driver, stalling receiver.
`timescale 1ns / 1ps

module modbus_rtu_read_probe_core_tb;
  import mbrp_pkg::*;

  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [1:0]  CFG_NONE      = 2'd3;
  localparam logic [15:0] TICK_MAX      = 16'hFFFF;
  localparam int          KEEP_ALL      = 1000;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          PHASE_ITEMS   = 45;
  localparam int          CYCLE_LIMIT   = 200000;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] probe_id;
    logic [7:0] rx_byte;
  } cmd_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic       found;
  } probe_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = CMD_TICK;
  logic [7:0]  in_probe_id = 8'h00;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_tx_byte;
  logic        out_last;
  logic        out_found;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_FIRST_REG;
  logic [15:0] cfg_data = 16'h0000;

  modbus_rtu_read_probe_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_command  (in_command),
    .in_probe_id (in_probe_id),
    .in_rx_byte  (in_rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_tx_byte (out_tx_byte),
    .out_last    (out_last),
    .out_found   (out_found),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #10 clk = ~clk;

  // Pending command beats and predicted probe output beats
  cmd_item_t   cmd_q[$];
  probe_beat_t probe_beats_q[$];

  // Predicted configuration
  logic [15:0] c_first_reg = FIRST_REG_RST;
  logic [6:0]  c_reg_cnt   = REG_COUNT_RST;
  logic [15:0] c_timeout   = TIMEOUT_RST;

  // Predicted probe state
  logic        p_active  = 1'b0;
  logic [7:0]  p_exp_id  = 8'h00;
  logic [8:0]  p_rx_cnt  = 9'd0;
  logic [15:0] p_crc     = CRC_INIT;
  logic [7:0]  p_hold0   = 8'h00;
  logic [7:0]  p_hold1   = 8'h00;
  logic [7:0]  p_first   = 8'h00;
  logic [7:0]  p_func    = 8'h00;
  logic [7:0]  p_count_b = 8'h00;
  logic [15:0] p_ticks   = 16'h0000;

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_found = 0;
  int n_lost = 0;
  int n_cfg = 0;
  int queued_total = 0;
  int ignored_total = 0;
  int hold_req = 0;
  int phase_timeout = 200;
  bit mix_ticks = 1'b0;

  // Reflected CRC16, one data bit per step
  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Close the probe with a verdict beat
  task automatic probe_verdict();
    probe_beat_t v;
    v.kind    = KIND_VERDICT;
    v.tx_byte = 8'h00;
    v.last    = 1'b0;
    v.found   = (p_rx_cnt >= RX_MIN) && (p_first == p_exp_id) && (p_func == FUNC_READ) &&
                ({p_hold1, p_hold0} == p_crc);
    probe_beats_q.insert(probe_beats_q.size(), v);
    p_active = 1'b0;
  endtask

  // Advance the probe by one accepted command beat
  task automatic probe_step(input logic [1:0] cmd, input logic [7:0] id, input logic [7:0] b);
    logic [7:0]  req [8];
    logic [15:0] crc;
    probe_beat_t t;
    case (cmd)
      CMD_START: begin
        req[0] = id;
        req[1] = FUNC_READ;
        req[2] = c_first_reg[15:8];
        req[3] = c_first_reg[7:0];
        req[4] = 8'h00;
        req[5] = {1'b0, c_reg_cnt};
        crc = CRC_INIT;
        for (int i = 0; i < 6; i++) begin
          crc = crc16_update(crc, req[i]);
        end
        req[6] = crc[7:0];
        req[7] = crc[15:8];
        for (int i = 0; i < 8; i++) begin
          t.kind    = KIND_TX;
          t.tx_byte = req[i];
          t.last    = (i == 7);
          t.found   = 1'b0;
          probe_beats_q.insert(probe_beats_q.size(), t);
        end
        // Restart reception from scratch
        p_exp_id  = id;
        p_rx_cnt  = 9'd0;
        p_crc     = CRC_INIT;
        p_hold0   = 8'h00;
        p_hold1   = 8'h00;
        p_first   = 8'h00;
        p_func    = 8'h00;
        p_count_b = 8'h00;
        p_ticks   = 16'h0000;
        p_active  = 1'b1;
      end
      CMD_BYTE: begin
        if (p_active) begin
          // CRC trails two bytes behind the newest one
          if (p_rx_cnt >= 9'd2) begin
            p_crc = crc16_update(p_crc, p_hold0);
          end
          p_hold0 = p_hold1;
          p_hold1 = b;
          if (p_rx_cnt == 9'd0) begin
            p_first = b;
          end else if (p_rx_cnt == 9'd1) begin
            p_func = b;
          end else if (p_rx_cnt == 9'd2) begin
            p_count_b = b;
          end
          if (p_rx_cnt < RX_MAX) begin
            p_rx_cnt = p_rx_cnt + 9'd1;
          end
          if (p_rx_cnt >= RX_MIN && p_func == FUNC_READ &&
              p_rx_cnt >= {1'b0, p_count_b} + RX_EXTRA) begin
            probe_verdict();
          end
        end
      end
      CMD_TICK: begin
        if (p_active) begin
          if (p_ticks != TICK_MAX) begin
            p_ticks = p_ticks + 16'd1;
          end
          if (p_ticks >= c_timeout) begin
            probe_verdict();
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Queue one command beat for the driver
  task automatic push_cmd(input logic [1:0] cmd, input logic [7:0] id, input logic [7:0] b);
    cmd_item_t it;
    it.command  = cmd;
    it.probe_id = id;
    it.rx_byte  = b;
    cmd_q.insert(cmd_q.size(), it);
    queued_total++;
  endtask

  task automatic push_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      push_cmd(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  // Queue a response frame, optionally with a broken CRC or cut short
  task automatic push_frame(input logic [7:0] addr, input logic [7:0] func, input int n_data,
                            input bit crc_bad, input int keep);
    logic [7:0]  fr[$];
    logic [15:0] crc;
    fr.insert(fr.size(), addr);
    fr.insert(fr.size(), func);
    fr.insert(fr.size(), n_data[7:0]);
    for (int i = 0; i < n_data; i++) begin
      fr.insert(fr.size(), 8'($urandom_range(0, 255)));
    end
    crc = CRC_INIT;
    foreach (fr[i]) begin
      crc = crc16_update(crc, fr[i]);
    end
    fr.insert(fr.size(), crc_bad ? crc[7:0] ^ 8'($urandom_range(1, 255)) : crc[7:0]);
    fr.insert(fr.size(), crc[15:8]);
    for (int i = 0; i < fr.size() && i < keep; i++) begin
      if (mix_ticks && $urandom_range(0, 15) == 0) begin
        push_cmd(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      push_cmd(CMD_BYTE, 8'($urandom_range(0, 255)), fr[i]);
    end
  endtask

  // Write one register and mirror it into the predicted configuration
  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_FIRST_REG: c_first_reg = data;
      CFG_REG_COUNT: c_reg_cnt   = data[6:0];
      CFG_TIMEOUT:   c_timeout   = data;
      default: begin
      end
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] first_reg, input logic [15:0] count,
                            input logic [15:0] tmo);
    cfg_write(CFG_FIRST_REG, first_reg);
    cfg_write(CFG_REG_COUNT, count);
    cfg_write(CFG_TIMEOUT, tmo);
    phase_timeout = int'(tmo);
  endtask

  // Wait until every queued beat is taken and every predicted beat has come out
  task automatic wait_idle();
    @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || probe_beats_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random probe exchange, mostly well formed
  task automatic random_exchange();
    logic [7:0] id;
    logic [7:0] id2;
    logic [7:0] f;
    int         r;
    int         n;
    id = 8'($urandom_range(0, 255));
    r  = $urandom_range(0, 99);
    n  = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    f  = 8'($urandom_range(0, 255));
    if (f == FUNC_READ) begin
      f = 8'h83;
    end
    if (r >= 92) begin
      // Noise that the probe ignores or that hits an idle probe
      push_cmd(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      push_cmd(CMD_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      push_cmd(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      ignored_total += 3;
    end else begin
      push_cmd(CMD_START, id, 8'($urandom_range(0, 255)));
      if (r < 40) begin
        push_frame(id, FUNC_READ, n, 1'b0, KEEP_ALL);
        push_ticks($urandom_range(0, 2));
      end else if (r < 50) begin
        push_frame(id, FUNC_READ, n, 1'b1, KEEP_ALL);
      end else if (r < 58) begin
        push_frame(id ^ 8'($urandom_range(1, 255)), FUNC_READ, n, 1'b0, KEEP_ALL);
      end else if (r < 66) begin
        push_frame(id, f, n, 1'b0, KEEP_ALL);
        push_ticks(phase_timeout + 1);
      end else if (r < 74) begin
        push_frame(id, FUNC_READ, n, 1'($urandom_range(0, 1)), $urandom_range(0, n + 4));
        push_ticks($urandom_range(1, phase_timeout + 1));
      end else if (r < 80) begin
        push_ticks(phase_timeout + 1);
      end else if (r < 86) begin
        // Restart in the middle of a reply
        id2 = 8'($urandom_range(0, 255));
        push_frame(id, FUNC_READ, n, 1'b0, $urandom_range(1, 4));
        push_cmd(CMD_START, id2, 8'($urandom_range(0, 255)));
        push_frame(id2, FUNC_READ, $urandom_range(0, 6), 1'b0, KEEP_ALL);
      end else begin
        for (int i = $urandom_range(1, 10); i > 0; i--) begin
          push_cmd(CMD_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        push_ticks(phase_timeout + 1);
      end
      if ($urandom_range(0, 7) == 0) begin
        push_cmd(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        ignored_total++;
      end
    end
  endtask

  // Driver: offer beats in bursts with random gaps, hold until accepted
  cmd_item_t drv_item;
  logic      in_taken = 1'b0;
  int        drv_burst = 1;
  int        drv_gap = 0;

  always @(negedge clk) begin
    if (in_valid && !in_taken) begin
      // hold the current beat
    end else if (drv_gap > 0) begin
      in_valid <= 1'b0;
      drv_gap  <= drv_gap - 1;
    end else if (cmd_q.size() > 0) begin
      drv_item    = cmd_q.pop_front();
      in_valid    <= 1'b1;
      in_command  <= drv_item.command;
      in_probe_id <= drv_item.probe_id;
      in_rx_byte  <= drv_item.rx_byte;
      if (drv_burst <= 1) begin
        drv_burst <= $urandom_range(1, 24);
        drv_gap   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        drv_burst <= drv_burst - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: stall on changing patterns, with an occasional long hold-off
  int rcv_mode = 0;
  int rcv_left = 0;
  int hold_left = 0;
  int hold_seen = 0;

  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (rcv_left == 0) begin
        rcv_mode <= $urandom_range(0, 3);
        rcv_left <= $urandom_range(8, 80);
      end else begin
        rcv_left <= rcv_left - 1;
      end
      case (rcv_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 0);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Monitor: check output beats in order, feed accepted input beats to the predictor
  probe_beat_t mon_want;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        n_out++;
        if (probe_beats_q.size() == 0) begin
          if (errors < 10) begin
            $display("ERROR: unexpected beat kind=%0d tx=%02h last=%0d found=%0d",
                     out_kind, out_tx_byte, out_last, out_found);
          end
          errors++;
        end else begin
          mon_want = probe_beats_q.pop_front();
          if (out_kind !== mon_want.kind || out_tx_byte !== mon_want.tx_byte ||
              out_last !== mon_want.last || out_found !== mon_want.found) begin
            if (errors < 10) begin
              $display("ERROR: beat %0d exp kind=%0d tx=%02h last=%0d found=%0d",
                       n_out, mon_want.kind, mon_want.tx_byte, mon_want.last, mon_want.found);
              $display("       got kind=%0d tx=%02h last=%0d found=%0d",
                       out_kind, out_tx_byte, out_last, out_found);
            end
            errors++;
          end
          if (mon_want.kind == KIND_VERDICT) begin
            if (mon_want.found) begin
              n_found++;
            end else begin
              n_lost++;
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        n_in++;
        probe_step(in_command, in_probe_id, in_rx_byte);
      end
    end
  end

  // Watchdog
  initial begin
    int wd_cycles;
    wd_cycles = 0;
    while (wd_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      wd_cycles++;
    end
    $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
    $display("modbus_rtu_read_probe_core: mismatch");
    $finish;
  end

  // Stimulus sequence
  initial begin
    int phase_base;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed: defaults, idle noise, address extremes
    push_cmd(CMD_UNUSED, 8'hFF, 8'hFF);
    push_cmd(CMD_BYTE, 8'h00, 8'h00);
    push_cmd(CMD_TICK, 8'h00, 8'hFF);
    push_cmd(CMD_START, 8'h00, 8'h00);
    push_frame(8'h00, FUNC_READ, 0, 1'b0, KEEP_ALL);
    push_cmd(CMD_START, 8'hFF, 8'hFF);
    push_frame(8'hFF, FUNC_READ, 1, 1'b0, KEEP_ALL);
    wait_idle();

    // Directed: top register, masked count, short timeout, unused index
    cfg_write(CFG_NONE, 16'h1234);
    set_config(16'hFFFF, 16'hFFFF, 16'd2);
    push_cmd(CMD_START, 8'h5A, 8'h00);
    push_cmd(CMD_START, 8'hA5, 8'h00);
    push_frame(8'hA5, 8'h83, 1, 1'b0, KEEP_ALL);
    push_ticks(2);
    push_cmd(CMD_START, 8'h11, 8'h00);
    push_cmd(CMD_BYTE, 8'h00, 8'h11);
    push_ticks(2);
    wait_idle();

    // Random phases over a spread of settings
    mix_ticks = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config(16'h0000, 16'd0, 16'd0);
        1: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 125)),
                      16'($urandom_range(1, 16)));
        2: set_config(16'hFFFF, 16'd125, 16'd24);
        default: set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 125)),
                            16'($urandom_range(3, 10)));
      endcase
      if (ph == 1 || ph == 3) begin
        hold_req++;
      end
      phase_base = queued_total - ignored_total;
      while (queued_total - ignored_total - phase_base < PHASE_ITEMS) begin
        random_exchange();
      end
      wait_idle();
    end

    // Long reply whose length runs past eight bits
    mix_ticks = 1'b0;
    set_config(16'($urandom_range(0, 65535)), 16'd1, 16'd8);
    push_cmd(CMD_START, 8'h3C, 8'h00);
    push_frame(8'h3C, FUNC_READ, 251, 1'b0, KEEP_ALL);
    push_ticks(2);
    wait_idle();
    repeat (20) @(posedge clk);

    if (probe_beats_q.size() != 0) begin
      $display("ERROR: %0d predicted beats never came out", probe_beats_q.size());
      errors++;
    end
    $display("Covered %0d command beats and %0d output beats over %0d register writes",
             n_in, n_out, n_cfg);
    $display("Verdicts: %0d slave found, %0d not found; %0d mismatches", n_found, n_lost, errors);
    if (errors == 0) begin
      $display("modbus_rtu_read_probe_core: match");
    end else begin
      $display("modbus_rtu_read_probe_core: mismatch");
    end
    $finish;
  end

endmodule
